// File: sv/rpa_pkg.sv
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared sizes, codes and interface structs of the page allocator.
// ----------------------------------------------------------------------------
package rpa_pkg;

  localparam int NUM_PAGES = 32768;
  localparam int PAGE_W    = $clog2(NUM_PAGES);
  localparam int CNT_W     = PAGE_W + 1;
  localparam int REF_BITS  = 8;
  localparam int CFG_W     = 16;
  localparam int OP_W      = 2;
  localparam int ST_W      = 2;

  typedef logic [PAGE_W-1:0]   page_t;
  typedef logic [REF_BITS-1:0] refcnt_t;
  typedef logic [CNT_W-1:0]    count_t;

  localparam refcnt_t REF_MAX  = {REF_BITS{1'b1}};
  localparam page_t   PAGE_MAX = {PAGE_W{1'b1}};

  // request codes
  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
  localparam logic [OP_W-1:0] OP_COW    = 2'd2;
  localparam logic [OP_W-1:0] OP_ADDREF = 2'd3;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NO_PAGE = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE   = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

  // configuration register indexes
  localparam logic CFG_FIRST_USABLE = 1'b0;
  localparam logic CFG_PAGE_LIMIT   = 1'b1;

  typedef struct packed {
    logic    we;
    page_t   addr;
    refcnt_t data;
  } ref_wr_t;

  typedef struct packed {
    logic  push;
    logic  pop;
    page_t page;
  } stk_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stk_sts_t;

endpackage

// File: sv/rpa_ref_mem.sv
// ----------------------------------------------------------------------------
// rpa_ref_mem
// Per-page reference count memory, one read and one write port, with a
// zeroing sweep after reset.
// ----------------------------------------------------------------------------
module rpa_ref_mem (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  rpa_pkg::page_t   rd_addr,
  output rpa_pkg::refcnt_t rd_data,
  input  rpa_pkg::ref_wr_t wr,
  output logic             busy
);

  rpa_pkg::refcnt_t mem [rpa_pkg::NUM_PAGES];
  rpa_pkg::refcnt_t rd_data_r;
  rpa_pkg::page_t   clr_idx_r;
  logic             clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == rpa_pkg::PAGE_MAX) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_busy_r;

endmodule

// File: sv/rpa_free_stack.sv
// ----------------------------------------------------------------------------
// rpa_free_stack
// LIFO of free page numbers in a synchronous memory plus the fill count.
// The top entry is read on request; data is ready the next cycle.
// ----------------------------------------------------------------------------
module rpa_free_stack (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_en,
  output rpa_pkg::page_t     rd_data,
  input  rpa_pkg::stk_cmd_t  cmd,
  output rpa_pkg::stk_sts_t  sts
);

  rpa_pkg::page_t  mem [rpa_pkg::NUM_PAGES];
  rpa_pkg::page_t  rd_data_r;
  rpa_pkg::count_t count_r;
  rpa_pkg::count_t count_m1;

  assign count_m1 = count_r - 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.push) begin
      count_r <= count_r + 1'b1;
    end else if (cmd.pop) begin
      count_r <= count_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[count_r[rpa_pkg::PAGE_W-1:0]] <= cmd.page;
    end
  end

  // read address is meaningless when empty; the data is then unused
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[count_m1[rpa_pkg::PAGE_W-1:0]];
    end
  end

  assign rd_data   = rd_data_r;
  assign sts.empty = (count_r == '0);
  assign sts.full  = (count_r == rpa_pkg::count_t'(rpa_pkg::NUM_PAGES));

endmodule

// File: sv/refcounted_page_allocator.sv
// Flow: an accepted item passes the execute state, then the copy-on-write state for a
// copy on write that takes a new page, then the done state, which holds while out_stall
// blocks a valid output and then registers the result. No new item is taken before
// that; each item reads, then writes, the count memory through its single write port.
// Reset: synchronous, active low. Afterwards the count memory is zeroed page by page,
// during which in_stall stays high; config writes are taken.
// ----------------------------------------------------------------------------
// refcounted_page_allocator
// Page allocator with a free page stack and per-page reference counts.
// ----------------------------------------------------------------------------
module refcounted_page_allocator (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [rpa_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [rpa_pkg::OP_W-1:0]  in_opcode,
  input  rpa_pkg::page_t            in_page_number,
  output logic                      out_valid,
  input  logic                      out_stall,
  output rpa_pkg::page_t            out_result_page,
  output logic [rpa_pkg::ST_W-1:0]  out_status,
  output rpa_pkg::refcnt_t          out_ref_count_after,
  output logic                      out_page_released
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_COW  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [rpa_pkg::CFG_W-1:0] first_r, limit_r;
  logic [rpa_pkg::OP_W-1:0]  req_op_r;
  rpa_pkg::page_t            req_page_r;

  rpa_pkg::page_t            res_page_r, res_page_nxt;
  logic [rpa_pkg::ST_W-1:0]  res_status_r, res_status_nxt;
  rpa_pkg::refcnt_t          res_rc_r, res_rc_nxt;
  logic                      res_rel_r, res_rel_nxt;
  rpa_pkg::refcnt_t          cow_cnt_r, cow_cnt_nxt;

  logic                      out_valid_r;
  rpa_pkg::page_t            out_page_r;
  logic [rpa_pkg::ST_W-1:0]  out_status_r;
  rpa_pkg::refcnt_t          out_rc_r;
  logic                      out_rel_r;
  logic                      out_load;

  logic                      in_acc;
  logic                      ref_busy;
  rpa_pkg::refcnt_t          ref_rd;
  rpa_pkg::ref_wr_t          ref_wr;
  rpa_pkg::page_t            stk_rd;
  rpa_pkg::stk_cmd_t         stk_cmd;
  rpa_pkg::stk_sts_t         stk_sts;

  rpa_pkg::refcnt_t          c_dec, c_inc;
  logic                      in_range;

  assign in_stall = ref_busy || (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  rpa_ref_mem u_ref_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (in_page_number),
    .rd_data (ref_rd),
    .wr      (ref_wr),
    .busy    (ref_busy)
  );

  rpa_free_stack u_free_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_data (stk_rd),
    .cmd     (stk_cmd),
    .sts     (stk_sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= '0;
      limit_r <= rpa_pkg::CFG_W'(rpa_pkg::NUM_PAGES);
    end else if (cfg_we) begin
      if (cfg_index == rpa_pkg::CFG_FIRST_USABLE) begin
        first_r <= cfg_wdata;
      end
      if (cfg_index == rpa_pkg::CFG_PAGE_LIMIT) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_op_r   <= in_opcode;
      req_page_r <= in_page_number;
    end
  end

  assign c_dec    = (ref_rd == '0) ? ref_rd : ref_rd - 1'b1;
  assign c_inc    = (ref_rd == rpa_pkg::REF_MAX) ? ref_rd : ref_rd + 1'b1;
  assign in_range = (rpa_pkg::CFG_W'(req_page_r) >= first_r) &&
                    (rpa_pkg::CFG_W'(req_page_r) < limit_r);

  always_comb begin
    state_nxt      = state_r;
    ref_wr         = '0;
    stk_cmd        = '0;
    res_page_nxt   = res_page_r;
    res_status_nxt = res_status_r;
    res_rc_nxt     = res_rc_r;
    res_rel_nxt    = res_rel_r;
    cow_cnt_nxt    = cow_cnt_r;
    out_load       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt      = S_DONE;
        res_page_nxt   = req_page_r;
        res_status_nxt = rpa_pkg::ST_OK;
        res_rc_nxt     = ref_rd;
        res_rel_nxt    = 1'b0;
        case (req_op_r)
          rpa_pkg::OP_ALLOC: begin
            if (stk_sts.empty) begin
              res_page_nxt   = '0;
              res_status_nxt = rpa_pkg::ST_NO_PAGE;
              res_rc_nxt     = '0;
            end else begin
              stk_cmd.pop  = 1'b1;
              ref_wr       = '{we: 1'b1, addr: stk_rd, data: rpa_pkg::refcnt_t'(1)};
              res_page_nxt = stk_rd;
              res_rc_nxt   = rpa_pkg::refcnt_t'(1);
            end
          end
          rpa_pkg::OP_FREE: begin
            if (!in_range) begin
              res_status_nxt = rpa_pkg::ST_RANGE;
              res_rc_nxt     = '0;
            end else begin
              ref_wr     = '{we: 1'b1, addr: req_page_r, data: c_dec};
              res_rc_nxt = c_dec;
              if (c_dec == '0) begin
                if (stk_sts.full) begin
                  res_status_nxt = rpa_pkg::ST_FULL;
                end else begin
                  stk_cmd.push = 1'b1;
                  stk_cmd.page = req_page_r;
                  res_rel_nxt  = 1'b1;
                end
              end
            end
          end
          rpa_pkg::OP_COW: begin
            if (ref_rd <= rpa_pkg::refcnt_t'(1)) begin
              // sole owner keeps its page
            end else if (stk_sts.empty) begin
              res_page_nxt   = '0;
              res_status_nxt = rpa_pkg::ST_NO_PAGE;
            end else begin
              stk_cmd.pop  = 1'b1;
              ref_wr       = '{we: 1'b1, addr: stk_rd, data: rpa_pkg::refcnt_t'(1)};
              res_page_nxt = stk_rd;
              // popped its own page: count was just set to 1, drop it to 0
              cow_cnt_nxt  = (stk_rd == req_page_r) ? '0 : c_dec;
              res_rc_nxt   = cow_cnt_nxt;
              state_nxt    = S_COW;
            end
          end
          rpa_pkg::OP_ADDREF: begin
            ref_wr     = '{we: 1'b1, addr: req_page_r, data: c_inc};
            res_rc_nxt = c_inc;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_COW: begin
        ref_wr    = '{we: 1'b1, addr: req_page_r, data: cow_cnt_r};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_page_r   <= res_page_nxt;
    res_status_r <= res_status_nxt;
    res_rc_r     <= res_rc_nxt;
    res_rel_r    <= res_rel_nxt;
    cow_cnt_r    <= cow_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_page_r   <= res_page_r;
      out_status_r <= res_status_r;
      out_rc_r     <= res_rc_r;
      out_rel_r    <= res_rel_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_page     = out_page_r;
  assign out_status          = out_status_r;
  assign out_ref_count_after = out_rc_r;
  assign out_page_released   = out_rel_r;

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_EXEC)
    else $error("accepted item did not move to execute");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    stk_cmd.pop |-> !stk_sts.empty)
    else $error("pop from empty free stack");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    stk_cmd.push |-> !stk_sts.full && !stk_cmd.pop)
    else $error("bad push on free stack");

  a_no_item_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ref_busy |-> state_r == S_IDLE && !ref_wr.we)
    else $error("count access during clearing sweep");
`endif

endmodule
